/* hw/rtl/rigid_body_motion_integrator_assert.svh */
// ---------------------------------------------------------------------------
// rigid body motion integrator: assertion macros
// immediate implication and next-cycle implication, both reset gated
// ---------------------------------------------------------------------------
`ifndef RIGID_BODY_MOTION_INTEGRATOR_ASSERT_SVH
`define RIGID_BODY_MOTION_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define RBMI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBMI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rbmi_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbmi_pkg
// shared widths, command and status types and saturating fixed-point helpers
// ---------------------------------------------------------------------------
package rbmi_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int MASS_BITS = 31;
  localparam int DT_BITS   = 31;
  localparam int OP_BITS   = 3;
  localparam int AXES      = 3;
  // dividend magnitude (one bit above the word for 2*|E|) shifted by the fraction
  localparam int DIVD_BITS = WORD_BITS + 1 + FRAC_BITS;
  localparam int ROOT_BITS = (WORD_BITS + FRAC_BITS) / 2;

  localparam logic [MASS_BITS-1:0] MASS_RESET = MASS_BITS'(65536);

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK    = 3'd0,
    OP_FORCE   = 3'd1,
    OP_ACCEL   = 3'd2,
    OP_IMPULSE = 3'd3,
    OP_ENERGY  = 3'd4,
    OP_PLACE   = 3'd5
  } op_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,      // latch the input word
    CMD_HALF,      // half = (dt*dt)/2
    CMD_TICK_V,    // tmp = dt*v
    CMD_TICK_A,    // tmp += half*a
    CMD_TICK_UPD,  // pos += tmp, v += dt*a
    CMD_SCALE,     // tmp = vec*magnitude
    CMD_ACC_TMP,   // acc += tmp
    CMD_DIV_TMP,   // start tmp/mass
    CMD_ACC_DIV,   // acc += quotient
    CMD_IMP,       // v += quotient*dt
    CMD_DIV_EN,    // start 2|E|/mass
    CMD_SQRT,      // start root of quotient
    CMD_DV,        // dv = signed root
    CMD_ENG,       // v += dv*vec
    CMD_PLACE,     // pos = vec, v = acc = 0
    CMD_OUT        // copy state into the result register
  } cmd_e;

  typedef struct packed {
    cmd_e       code;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic en_zero;
  } stat_t;

  // saturate a sign and magnitude to the signed word
  function automatic word_t sat_mag(input logic neg, input logic [DIVD_BITS-1:0] m);
    logic [DIVD_BITS-1:0] top;
    word_t                low;
    top = DIVD_BITS'(WORD_MAX);
    low = word_t'(m[WORD_BITS-1:0]);
    if (m > top) return neg ? WORD_MIN : WORD_MAX;
    return neg ? -low : low;
  endfunction

  // truncating fixed-point product with saturation
  function automatic word_t mul_fix(input word_t a, input word_t b);
    logic [WORD_BITS-1:0]   ma;
    logic [WORD_BITS-1:0]   mb;
    logic [2*WORD_BITS-1:0] p;
    ma = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    mb = b[WORD_BITS-1] ? (~b + 1'b1) : b;
    p  = {{WORD_BITS{1'b0}}, ma} * {{WORD_BITS{1'b0}}, mb};
    return sat_mag(a[WORD_BITS-1] ^ b[WORD_BITS-1],
                   DIVD_BITS'(p[2*WORD_BITS-1:FRAC_BITS]));
  endfunction

  // saturating add
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return s[WORD_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/rbmi_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbmi_div
// restoring divider, one quotient bit per cycle, done pulse at the end
// ---------------------------------------------------------------------------
module rbmi_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rbmi_pkg::DIVD_BITS-1:0]     dividend_i,
  input  logic [rbmi_pkg::MASS_BITS-1:0]     divisor_i,
  output logic [rbmi_pkg::DIVD_BITS-1:0]     quotient_o,
  output logic                               done_o
);

  localparam int CNT_BITS = $clog2(rbmi_pkg::DIVD_BITS + 1);
  localparam int REM_BITS = rbmi_pkg::MASS_BITS + 1;

  logic [REM_BITS-1:0]                rem_q, rem_d;
  logic [rbmi_pkg::DIVD_BITS-1:0]     quo_q, quo_d;
  logic [CNT_BITS-1:0]                cnt_q;
  logic                               done_q;
  logic [REM_BITS:0]                  shifted;
  logic [REM_BITS:0]                  dsor;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[rbmi_pkg::DIVD_BITS-1]};
    dsor    = (REM_BITS+1)'(divisor_i);
    if (shifted >= dsor) begin
      rem_d = REM_BITS'(shifted - dsor);
      quo_d = {quo_q[rbmi_pkg::DIVD_BITS-2:0], 1'b1};
    end else begin
      rem_d = REM_BITS'(shifted);
      quo_d = {quo_q[rbmi_pkg::DIVD_BITS-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_BITS'(1));
      if (start_i) begin
        cnt_q <= CNT_BITS'(rbmi_pkg::DIVD_BITS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* hw/rtl/rbmi_sqrt.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbmi_sqrt
// digit-by-digit integer square root of value << fraction, one bit per cycle
// ---------------------------------------------------------------------------
module rbmi_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rbmi_pkg::WORD_BITS-1:0]     value_i,
  output logic [rbmi_pkg::ROOT_BITS-1:0]     root_o,
  output logic                               done_o
);

  localparam int RAD_BITS = 2 * rbmi_pkg::ROOT_BITS;
  localparam int REM_BITS = rbmi_pkg::ROOT_BITS + 2;
  localparam int CNT_BITS = $clog2(rbmi_pkg::ROOT_BITS + 1);

  logic [RAD_BITS-1:0]            rad_q;
  logic [REM_BITS-1:0]            rem_q, rem_d;
  logic [rbmi_pkg::ROOT_BITS-1:0] root_q, root_d;
  logic [CNT_BITS-1:0]            cnt_q;
  logic                           done_q;
  logic [REM_BITS+1:0]            part;
  logic [REM_BITS+1:0]            trial;

  // one root digit
  always_comb begin
    part  = {rem_q, rad_q[RAD_BITS-1:RAD_BITS-2]};
    trial = (REM_BITS+2)'({root_q, 2'b01});
    if (part >= trial) begin
      rem_d  = REM_BITS'(part - trial);
      root_d = {root_q[rbmi_pkg::ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_d  = REM_BITS'(part);
      root_d = {root_q[rbmi_pkg::ROOT_BITS-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_BITS'(1));
      if (start_i) begin
        cnt_q <= CNT_BITS'(rbmi_pkg::ROOT_BITS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // radicand, remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= RAD_BITS'({value_i, {rbmi_pkg::FRAC_BITS{1'b0}}});
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

/* hw/rtl/rbmi_dpath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbmi_dpath
// body state, input latch, shared multiplier, divider, root unit, result word
// ---------------------------------------------------------------------------
module rbmi_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rbmi_pkg::cmd_t                   cmd_i,
  output rbmi_pkg::stat_t                  stat_o,
  input  logic                             cfg_we_i,
  input  logic [rbmi_pkg::MASS_BITS-1:0]   body_mass_i,
  input  rbmi_pkg::word_t                  vec_x_i,
  input  rbmi_pkg::word_t                  vec_y_i,
  input  rbmi_pkg::word_t                  vec_z_i,
  input  rbmi_pkg::word_t                  magnitude_i,
  input  logic [rbmi_pkg::DT_BITS-1:0]     time_step_i,
  input  rbmi_pkg::word_t                  energy_i,
  output rbmi_pkg::word_t                  pos_o [rbmi_pkg::AXES],
  output rbmi_pkg::word_t                  vel_o [rbmi_pkg::AXES],
  output rbmi_pkg::word_t                  acc_o [rbmi_pkg::AXES]
);

  rbmi_pkg::word_t pos_q [rbmi_pkg::AXES];
  rbmi_pkg::word_t vel_q [rbmi_pkg::AXES];
  rbmi_pkg::word_t acc_q [rbmi_pkg::AXES];
  rbmi_pkg::word_t vec_q [rbmi_pkg::AXES];
  rbmi_pkg::word_t out_pos_q [rbmi_pkg::AXES];
  rbmi_pkg::word_t out_vel_q [rbmi_pkg::AXES];
  rbmi_pkg::word_t out_acc_q [rbmi_pkg::AXES];
  rbmi_pkg::word_t mag_q, en_q, half_q, tmp_q, dv_q;
  logic [rbmi_pkg::DT_BITS-1:0]   dt_q;
  logic [rbmi_pkg::MASS_BITS-1:0] mass_q;
  logic [rbmi_pkg::MASS_BITS-1:0] mass_eff;
  logic                           div_neg_q;

  rbmi_pkg::word_t mul_a, mul_b, prod, dt_w, quo_sat, root_w;
  logic [rbmi_pkg::WORD_BITS-1:0]  tmp_mag, en_mag;
  logic [rbmi_pkg::DIVD_BITS-1:0]  dividend, quotient;
  logic [rbmi_pkg::ROOT_BITS-1:0]  root;
  logic                            div_start, sqrt_start, div_done, sqrt_done;
  logic [1:0]                      ax;

  assign ax       = cmd_i.axis;
  assign dt_w     = rbmi_pkg::word_t'({1'b0, dt_q});
  assign mass_eff = (mass_q == '0) ? rbmi_pkg::MASS_BITS'(1) : mass_q;
  assign tmp_mag  = tmp_q[rbmi_pkg::WORD_BITS-1] ? (~tmp_q + 1'b1) : tmp_q;
  assign en_mag   = en_q[rbmi_pkg::WORD_BITS-1] ? (~en_q + 1'b1) : en_q;
  assign quo_sat  = rbmi_pkg::sat_mag(div_neg_q, quotient);
  assign root_w   = rbmi_pkg::word_t'(root);

  // shared multiplier operand select
  always_comb begin
    mul_a = dt_w;
    mul_b = dt_w;
    unique case (cmd_i.code)
      rbmi_pkg::CMD_TICK_V: begin
        mul_a = dt_w;
        mul_b = vel_q[ax];
      end
      rbmi_pkg::CMD_TICK_A: begin
        mul_a = half_q;
        mul_b = acc_q[ax];
      end
      rbmi_pkg::CMD_TICK_UPD: begin
        mul_a = dt_w;
        mul_b = acc_q[ax];
      end
      rbmi_pkg::CMD_SCALE: begin
        mul_a = vec_q[ax];
        mul_b = mag_q;
      end
      rbmi_pkg::CMD_IMP: begin
        mul_a = quo_sat;
        mul_b = dt_w;
      end
      rbmi_pkg::CMD_ENG: begin
        mul_a = dv_q;
        mul_b = vec_q[ax];
      end
      default: begin
        mul_a = dt_w;
        mul_b = dt_w;
      end
    endcase
  end

  assign prod = rbmi_pkg::mul_fix(mul_a, mul_b);

  // divider and root unit starts
  assign div_start  = (cmd_i.code == rbmi_pkg::CMD_DIV_TMP) ||
                      (cmd_i.code == rbmi_pkg::CMD_DIV_EN);
  assign sqrt_start = (cmd_i.code == rbmi_pkg::CMD_SQRT);
  assign dividend   = (cmd_i.code == rbmi_pkg::CMD_DIV_EN) ?
                      {en_mag, 1'b0, {rbmi_pkg::FRAC_BITS{1'b0}}} :
                      {1'b0, tmp_mag, {rbmi_pkg::FRAC_BITS{1'b0}}};

  rbmi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (mass_eff),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  rbmi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (quo_sat),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  assign stat_o = '{div_done: div_done, sqrt_done: sqrt_done, en_zero: (en_q == '0)};

  // mass register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= rbmi_pkg::MASS_RESET;
    end else if (cfg_we_i) begin
      mass_q <= body_mass_i;
    end
  end

  // body state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rbmi_pkg::AXES; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else begin
      unique case (cmd_i.code)
        rbmi_pkg::CMD_TICK_UPD: begin
          pos_q[ax] <= rbmi_pkg::sat_add(pos_q[ax], tmp_q);
          vel_q[ax] <= rbmi_pkg::sat_add(vel_q[ax], prod);
        end
        rbmi_pkg::CMD_ACC_TMP: acc_q[ax] <= rbmi_pkg::sat_add(acc_q[ax], tmp_q);
        rbmi_pkg::CMD_ACC_DIV: acc_q[ax] <= rbmi_pkg::sat_add(acc_q[ax], quo_sat);
        rbmi_pkg::CMD_IMP,
        rbmi_pkg::CMD_ENG:     vel_q[ax] <= rbmi_pkg::sat_add(vel_q[ax], prod);
        rbmi_pkg::CMD_PLACE: begin
          for (int i = 0; i < rbmi_pkg::AXES; i++) begin
            pos_q[i] <= vec_q[i];
            vel_q[i] <= '0;
            acc_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // input latch, scratch registers and result word
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.code)
      rbmi_pkg::CMD_LOAD: begin
        vec_q[0] <= vec_x_i;
        vec_q[1] <= vec_y_i;
        vec_q[2] <= vec_z_i;
        mag_q    <= magnitude_i;
        dt_q     <= time_step_i;
        en_q     <= energy_i;
      end
      rbmi_pkg::CMD_HALF:    half_q <= prod >>> 1;
      rbmi_pkg::CMD_TICK_V,
      rbmi_pkg::CMD_SCALE:   tmp_q  <= prod;
      rbmi_pkg::CMD_TICK_A:  tmp_q  <= rbmi_pkg::sat_add(tmp_q, prod);
      rbmi_pkg::CMD_DIV_TMP: div_neg_q <= tmp_q[rbmi_pkg::WORD_BITS-1];
      rbmi_pkg::CMD_DIV_EN:  div_neg_q <= 1'b0;
      rbmi_pkg::CMD_DV:      dv_q <= en_q[rbmi_pkg::WORD_BITS-1] ? -root_w : root_w;
      rbmi_pkg::CMD_OUT: begin
        out_pos_q <= pos_q;
        out_vel_q <= vel_q;
        out_acc_q <= acc_q;
      end
      default: ;
    endcase
  end

  assign pos_o = out_pos_q;
  assign vel_o = out_vel_q;
  assign acc_o = out_acc_q;

endmodule

/* hw/rtl/rbmi_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbmi_ctrl
// operation sequencer: steps the datapath per axis and owns the handshakes
// ---------------------------------------------------------------------------
module rbmi_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rbmi_pkg::OP_BITS-1:0]    operation_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rbmi_pkg::cmd_t                  cmd_o,
  input  rbmi_pkg::stat_t                 stat_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_HALF, S_TICK_V, S_TICK_A, S_TICK_UPD, S_SCALE, S_ACC_TMP,
    S_DIV_TMP, S_DIV_WAIT, S_ACC_DIV, S_IMP, S_EN_CHECK, S_DIV_EN,
    S_EN_WAIT, S_SQRT, S_SQRT_WAIT, S_DV, S_ENG, S_PLACE, S_DONE
  } state_e;

  state_e          state_q;
  rbmi_pkg::op_e   op_q;
  logic [1:0]      ax_q;
  logic            out_valid_q;
  logic            last_ax;
  logic            out_free;
  rbmi_pkg::cmd_e  code;

  assign last_ax  = (ax_q == 2'(rbmi_pkg::AXES - 1));
  assign out_free = !out_valid_q || out_ready_i;

  // command decode
  always_comb begin
    unique case (state_q)
      S_IDLE:      code = in_valid_i ? rbmi_pkg::CMD_LOAD : rbmi_pkg::CMD_NONE;
      S_HALF:      code = rbmi_pkg::CMD_HALF;
      S_TICK_V:    code = rbmi_pkg::CMD_TICK_V;
      S_TICK_A:    code = rbmi_pkg::CMD_TICK_A;
      S_TICK_UPD:  code = rbmi_pkg::CMD_TICK_UPD;
      S_SCALE:     code = rbmi_pkg::CMD_SCALE;
      S_ACC_TMP:   code = rbmi_pkg::CMD_ACC_TMP;
      S_DIV_TMP:   code = rbmi_pkg::CMD_DIV_TMP;
      S_ACC_DIV:   code = rbmi_pkg::CMD_ACC_DIV;
      S_IMP:       code = rbmi_pkg::CMD_IMP;
      S_DIV_EN:    code = rbmi_pkg::CMD_DIV_EN;
      S_SQRT:      code = rbmi_pkg::CMD_SQRT;
      S_DV:        code = rbmi_pkg::CMD_DV;
      S_ENG:       code = rbmi_pkg::CMD_ENG;
      S_PLACE:     code = rbmi_pkg::CMD_PLACE;
      S_DONE:      code = out_free ? rbmi_pkg::CMD_OUT : rbmi_pkg::CMD_NONE;
      default:     code = rbmi_pkg::CMD_NONE;
    endcase
  end

  assign cmd_o       = '{code: code, axis: ax_q};
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= rbmi_pkg::OP_TICK;
      ax_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the done step reloads the flag itself
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q <= rbmi_pkg::op_e'(operation_i);
            ax_q <= '0;
            unique case (operation_i)
              rbmi_pkg::OP_TICK:    state_q <= S_HALF;
              rbmi_pkg::OP_FORCE,
              rbmi_pkg::OP_ACCEL,
              rbmi_pkg::OP_IMPULSE: state_q <= S_SCALE;
              rbmi_pkg::OP_ENERGY:  state_q <= S_EN_CHECK;
              rbmi_pkg::OP_PLACE:   state_q <= S_PLACE;
              default:              state_q <= S_DONE;
            endcase
          end
        end
        S_HALF:     state_q <= S_TICK_V;
        S_TICK_V:   state_q <= S_TICK_A;
        S_TICK_A:   state_q <= S_TICK_UPD;
        S_TICK_UPD: begin
          ax_q    <= 2'(ax_q + 2'd1);
          state_q <= last_ax ? S_DONE : S_TICK_V;
        end
        S_SCALE:    state_q <= (op_q == rbmi_pkg::OP_ACCEL) ? S_ACC_TMP : S_DIV_TMP;
        S_ACC_TMP,
        S_ACC_DIV,
        S_IMP: begin
          ax_q    <= 2'(ax_q + 2'd1);
          state_q <= last_ax ? S_DONE : S_SCALE;
        end
        S_DIV_TMP:  state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (stat_i.div_done) begin
            state_q <= (op_q == rbmi_pkg::OP_FORCE) ? S_ACC_DIV : S_IMP;
          end
        end
        S_EN_CHECK: state_q <= stat_i.en_zero ? S_DONE : S_DIV_EN;
        S_DIV_EN:   state_q <= S_EN_WAIT;
        S_EN_WAIT:  if (stat_i.div_done) state_q <= S_SQRT;
        S_SQRT:     state_q <= S_SQRT_WAIT;
        S_SQRT_WAIT: if (stat_i.sqrt_done) state_q <= S_DV;
        S_DV:       state_q <= S_ENG;
        S_ENG: begin
          ax_q    <= 2'(ax_q + 2'd1);
          state_q <= last_ax ? S_DONE : S_ENG;
        end
        S_PLACE:    state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default:    state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/rigid_body_motion_integrator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rigid_body_motion_integrator
// constant-acceleration integrator for one body, Q16.16 state vectors
// ---------------------------------------------------------------------------
// channel | handshake                     | word
// in      | in_valid_i / in_ready_o       | operation, vec, magnitude, dt, energy
// out     | out_valid_o / out_ready_i     | position, velocity, acceleration
// cfg     | cfg_valid_i / cfg_ready_o     | body_mass (always ready)
//
// one word at a time. force, impulse and energy run through the one-bit-per-cycle
// divider (49 steps), energy also through the 24-step root unit; the shared
// multiplier does the rest. a new word is taken as soon as the previous result
// sits in the output register; a stalled result holds the sequencer at its last
// step. reset clears the state and sets the mass to 1.0.
// ---------------------------------------------------------------------------
module rigid_body_motion_integrator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rbmi_pkg::OP_BITS-1:0]    operation_i,
  input  logic signed [31:0]              vec_x_i,
  input  logic signed [31:0]              vec_y_i,
  input  logic signed [31:0]              vec_z_i,
  input  logic signed [31:0]              magnitude_i,
  input  logic [rbmi_pkg::DT_BITS-1:0]    time_step_i,
  input  logic signed [31:0]              energy_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              pos_x_o,
  output logic signed [31:0]              pos_y_o,
  output logic signed [31:0]              pos_z_o,
  output logic signed [31:0]              vel_x_o,
  output logic signed [31:0]              vel_y_o,
  output logic signed [31:0]              vel_z_o,
  output logic signed [31:0]              acc_x_o,
  output logic signed [31:0]              acc_y_o,
  output logic signed [31:0]              acc_z_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbmi_pkg::MASS_BITS-1:0]  body_mass_i
);

  rbmi_pkg::cmd_t  cmd;
  rbmi_pkg::stat_t stat;
  rbmi_pkg::word_t pos [rbmi_pkg::AXES];
  rbmi_pkg::word_t vel [rbmi_pkg::AXES];
  rbmi_pkg::word_t acc [rbmi_pkg::AXES];

  // mass writes are taken at any time
  assign cfg_ready_o = 1'b1;

  rbmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rbmi_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i),
    .body_mass_i (body_mass_i),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .magnitude_i (magnitude_i),
    .time_step_i (time_step_i),
    .energy_i    (energy_i),
    .pos_o       (pos),
    .vel_o       (vel),
    .acc_o       (acc)
  );

  assign pos_x_o = pos[0];
  assign pos_y_o = pos[1];
  assign pos_z_o = pos[2];
  assign vel_x_o = vel[0];
  assign vel_y_o = vel[1];
  assign vel_z_o = vel[2];
  assign acc_x_o = acc[0];
  assign acc_y_o = acc[1];
  assign acc_z_o = acc[2];

endmodule

/* hw/rtl/rbmi_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbmi_checker
// port-level checks on the integrator handshakes, bound to the top level
// ---------------------------------------------------------------------------
`include "rigid_body_motion_integrator_assert.svh"

module rbmi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] pos_x_o,
  input logic signed [31:0] vel_x_o,
  input logic signed [31:0] acc_x_o
);

  // a pending result stays offered
  `RBMI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // a stalled result keeps its x-axis position, velocity and acceleration
  `RBMI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(pos_x_o) && $stable(vel_x_o) && $stable(acc_x_o), "result word changed while stalled")

  // one word at a time: input closes after an accept
  `RBMI_ASSERT_NEXT(a_in_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "second word taken while busy")

  // a new result reopens the input
  `RBMI_ASSERT_NOW(a_done_ready, clk_i, rst_ni, $rose(out_valid_o), in_ready_o, "input not reopened with result")

endmodule

bind rigid_body_motion_integrator rbmi_checker u_rbmi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_x_o     (pos_x_o),
  .vel_x_o     (vel_x_o),
  .acc_x_o     (acc_x_o)
);
